[design/frp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg
// Types, codes and constants shared by the FASTA record parser modules.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int DEFAULT_LENGTH_BITS = 24;
  localparam int DEFAULT_COUNT_BITS  = 16;

  localparam int LEN_FIELD_W = 24;
  localparam int CNT_FIELD_W = 16;

  localparam int MAX_RESULTS = 3;
  localparam int STEP_BITS   = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_HBYTE = 3'd0,
    KIND_SBYTE = 3'd1,
    KIND_HEND  = 3'd2,
    KIND_REND  = 3'd3,
    KIND_DONE  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CMD_HBYTE         = 3'd0,
    CMD_SBYTE         = 3'd1,
    CMD_HEND          = 3'd2,
    CMD_REND          = 3'd3,
    CMD_DONE          = 3'd4,
    CMD_REND_DONE     = 3'd5,
    CMD_HEND_REND_DONE = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             out_byte;
    logic [LEN_FIELD_W-1:0] position_or_length;
    logic [CNT_FIELD_W-1:0] records_found;
    logic [LEN_FIELD_W-1:0] longest_sequence;
    logic                   stopped_early;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    cmd_e                   op;
    logic [7:0]             data;
    logic [LEN_FIELD_W-1:0] value;
    logic [CNT_FIELD_W-1:0] records;
    logic [LEN_FIELD_W-1:0] longest;
    logic                   stop;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic [LEN_FIELD_W-1:0] len_field(input logic [31:0] v);
    return v[LEN_FIELD_W-1:0];
  endfunction

  function automatic logic [CNT_FIELD_W-1:0] cnt_field(input logic [31:0] v);
    return v[CNT_FIELD_W-1:0];
  endfunction

endpackage

[design/frp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_front
// Parse state machine: classifies each byte, keeps the counters and issues
// one command per byte that causes results.
// ----------------------------------------------------------------------------
module frp_front
  import frp_pkg::*;
#(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS,
  parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    PH_SEEK   = 5'b00001,
    PH_LEAD   = 5'b00010,
    PH_HEADER = 5'b00100,
    PH_SEQ    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LENGTH_BITS-1:0] hdr_trim_q, hdr_trim_d;
  logic [LENGTH_BITS-1:0] seq_cnt_q, seq_cnt_d;
  logic [COUNT_BITS-1:0]  rec_q, rec_d;
  logic [LENGTH_BITS-1:0] longest_q, longest_d;

  logic [LENGTH_BITS-1:0] hdr_inc, seq_inc;
  logic [COUNT_BITS-1:0]  rec_inc;
  logic                   fire;
  logic [7:0]             b;
  logic                   eof;

  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign b          = in_item_i.in_byte;
  assign eof        = in_item_i.end_of_file;

  assign hdr_inc = (hdr_cnt_q == '1) ? hdr_cnt_q : hdr_cnt_q + 1'b1;
  assign seq_inc = (seq_cnt_q == '1) ? seq_cnt_q : seq_cnt_q + 1'b1;
  assign rec_inc = (rec_q == '1) ? rec_q : rec_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    hdr_trim_d  = hdr_trim_q;
    seq_cnt_d   = seq_cnt_q;
    rec_d       = rec_q;
    longest_d   = longest_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = CMD_HBYTE;
    if (fire) begin
      unique case (phase_q)
        PH_SEEK: begin
          if (eof) begin
            cmd_valid_o   = 1'b1;
            cmd_o.op      = CMD_DONE;
            cmd_o.records = cnt_field(32'(rec_q));
            cmd_o.longest = len_field(32'(longest_q));
            phase_d       = PH_DONE;
          end else if (b == CHAR_GT) begin
            hdr_cnt_d  = '0;
            hdr_trim_d = '0;
            phase_d    = PH_LEAD;
          end
        end
        PH_LEAD, PH_HEADER: begin
          if (eof) begin
            cmd_valid_o   = 1'b1;
            cmd_o.records = cnt_field(32'(rec_q));
            cmd_o.longest = len_field(32'(longest_q));
            phase_d       = PH_DONE;
            if (phase_q == PH_HEADER) begin
              cmd_o.op    = CMD_HEND_REND_DONE;
              cmd_o.value = len_field(32'(hdr_trim_q));
              cmd_o.stop  = 1'b1;
            end else begin
              cmd_o.op    = CMD_DONE;
            end
          end else if (phase_q == PH_HEADER || (b != CHAR_SPACE && b != CHAR_TAB)) begin
            cmd_valid_o = 1'b1;
            if (b == CHAR_LF) begin
              cmd_o.op    = CMD_HEND;
              cmd_o.value = len_field(32'(hdr_trim_q));
              seq_cnt_d   = '0;
              phase_d     = PH_SEQ;
            end else begin
              cmd_o.op    = CMD_HBYTE;
              cmd_o.data  = b;
              cmd_o.value = len_field(32'(hdr_cnt_q));
              hdr_cnt_d   = hdr_inc;
              if (!is_ws(b)) begin
                hdr_trim_d = hdr_inc;
              end
              phase_d     = PH_HEADER;
            end
          end
        end
        PH_SEQ: begin
          if (eof || b == CHAR_GT) begin
            cmd_valid_o = 1'b1;
            cmd_o.value = len_field(32'(seq_cnt_q));
            if (seq_cnt_q == '0) begin
              cmd_o.op      = CMD_REND_DONE;
              cmd_o.records = cnt_field(32'(rec_q));
              cmd_o.longest = len_field(32'(longest_q));
              cmd_o.stop    = 1'b1;
              phase_d       = PH_DONE;
            end else begin
              rec_d = rec_inc;
              if (seq_cnt_q > longest_q) begin
                longest_d = seq_cnt_q;
              end
              cmd_o.records = cnt_field(32'(rec_d));
              cmd_o.longest = len_field(32'(longest_d));
              if (eof) begin
                cmd_o.op = CMD_REND_DONE;
                phase_d  = PH_DONE;
              end else begin
                cmd_o.op   = CMD_REND;
                hdr_cnt_d  = '0;
                hdr_trim_d = '0;
                phase_d    = PH_LEAD;
              end
            end
          end else if (!is_ws(b)) begin
            cmd_valid_o = 1'b1;
            cmd_o.op    = CMD_SBYTE;
            cmd_o.data  = b;
            cmd_o.value = len_field(32'(seq_cnt_q));
            seq_cnt_d   = seq_inc;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEEK;
      hdr_cnt_q  <= '0;
      hdr_trim_q <= '0;
      seq_cnt_q  <= '0;
      rec_q      <= '0;
      longest_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      hdr_trim_q <= hdr_trim_d;
      seq_cnt_q  <= seq_cnt_d;
      rec_q      <= rec_d;
      longest_q  <= longest_d;
    end
  end

endmodule

[design/frp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_queue
// Short command FIFO between the parse front and the result sequencer.
// ----------------------------------------------------------------------------
module frp_queue
  import frp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] fill_q, fill_d;
  logic                do_push, do_pop;

  assign push_ready_o = (fill_q != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

[design/frp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_back
// Result sequencer: expands each command into one to three result transfers
// and holds them in the output register.
// ----------------------------------------------------------------------------
module frp_back
  import frp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [STEP_BITS-1:0] step_q, step_d;
  logic [STEP_BITS-1:0] last_step;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;
  out_item_t            res;
  logic                 load;
  logic                 is_last;

  assign load    = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (step_q == last_step);

  always_comb begin
    unique case (cmd_i.op)
      CMD_REND_DONE:      last_step = STEP_BITS'(1);
      CMD_HEND_REND_DONE: last_step = STEP_BITS'(2);
      default:            last_step = '0;
    endcase
  end

  always_comb begin
    res      = '0;
    res.kind = KIND_DONE;
    res.last = is_last;
    unique case (cmd_i.op)
      CMD_HBYTE: begin
        res.kind               = KIND_HBYTE;
        res.out_byte           = cmd_i.data;
        res.position_or_length = cmd_i.value;
      end
      CMD_SBYTE: begin
        res.kind               = KIND_SBYTE;
        res.out_byte           = cmd_i.data;
        res.position_or_length = cmd_i.value;
      end
      CMD_HEND: begin
        res.kind               = KIND_HEND;
        res.position_or_length = cmd_i.value;
      end
      CMD_REND: begin
        res.kind               = KIND_REND;
        res.position_or_length = cmd_i.value;
      end
      CMD_REND_DONE: begin
        if (step_q == '0) begin
          res.kind               = KIND_REND;
          res.position_or_length = cmd_i.value;
        end else begin
          res.kind             = KIND_DONE;
          res.records_found    = cmd_i.records;
          res.longest_sequence = cmd_i.longest;
          res.stopped_early    = cmd_i.stop;
        end
      end
      CMD_HEND_REND_DONE: begin
        if (step_q == '0) begin
          res.kind               = KIND_HEND;
          res.position_or_length = cmd_i.value;
        end else if (step_q == STEP_BITS'(1)) begin
          res.kind = KIND_REND;
        end else begin
          res.kind             = KIND_DONE;
          res.records_found    = cmd_i.records;
          res.longest_sequence = cmd_i.longest;
          res.stopped_early    = cmd_i.stop;
        end
      end
      default: begin
        res.kind             = KIND_DONE;
        res.records_found    = cmd_i.records;
        res.longest_sequence = cmd_i.longest;
        res.stopped_early    = cmd_i.stop;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_ready_o = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        cmd_ready_o = 1'b1;
        step_d      = '0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a command being expanded stays at the queue head until its last result
  a_step_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> cmd_valid_i)
    else $error("frp_back: command left the queue mid-expansion");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_BITS'(MAX_RESULTS - 1))
    else $error("frp_back: step counter out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.kind == KIND_DONE) |-> out_item_o.last)
    else $error("frp_back: file-done transfer not marked last");

  a_stop_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.kind != KIND_DONE) |-> !out_item_o.stopped_early)
    else $error("frp_back: stopped_early set outside file done");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !is_last) |=> (step_q != '0))
    else $error("frp_back: multi-result command not advanced");

endmodule

[design/fasta_record_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_record_parser
// Streaming FASTA parser: header bytes, sequence bytes and record summaries.
// ----------------------------------------------------------------------------
// Takes one text byte (or an end-of-file mark) per transfer and accepts a new
// byte every cycle while the queue is not full. Each byte is classified
// combinationally by the parse front, which queues at most one command into
// a two-entry queue; the output sequencer turns a command into one to three
// result transfers, one per cycle while the output is not stalled, so an end
// of file inside a header yields three transfers and a record end at end of
// file two. Input stalls only when the queue is full. After file done all
// input is taken and dropped until reset.
module fasta_record_parser
  import frp_pkg::*;
#(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS,
  parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  frp_front #(
    .LENGTH_BITS(LENGTH_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  frp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_cmd),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_data_o  (back_cmd)
  );

  frp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(back_valid),
    .cmd_ready_o(back_ready),
    .cmd_i      (back_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

[tb/tb_fasta_record_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fasta_record_parser
// Self-checking bench: FASTA byte stream in, parse results checked in order.
// ----------------------------------------------------------------------------
// Unless the run ends before any header, a short table of hand-picked bytes
// opens the file, then random records follow with noise bytes mixed in. One
// way of closing the file is picked per run. A local parse model predicts
// every result transfer; random gaps and stalls are applied on both channels.
module tb_fasta_record_parser;
  import frp_pkg::*;

  localparam int LEN_W        = LEN_FIELD_W;
  localparam int CNT_W        = CNT_FIELD_W;
  localparam int ITEM_TARGET  = 180;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  typedef enum logic [2:0] {
    SCAN_FOR_MARK,
    SKIP_BLANKS,
    IN_HEADER,
    IN_SEQUENCE,
    FILE_CLOSED
  } parse_state_e;

  typedef enum int {
    END_IN_SEQUENCE,
    END_IN_HEADER,
    END_IN_LEAD,
    END_EMPTY_BY_MARK,
    END_EMPTY_BY_EOF,
    END_BEFORE_HEADER
  } file_end_e;

  typedef struct {
    logic [7:0] ch;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  fasta_record_parser DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parse model state
  parse_state_e     pstate      = SCAN_FOR_MARK;
  logic [LEN_W-1:0] hdr_pos     = '0;
  logic [LEN_W-1:0] hdr_trim    = '0;
  logic [LEN_W-1:0] seq_len     = '0;
  logic [CNT_W-1:0] rec_count   = '0;
  logic [LEN_W-1:0] max_seq_len = '0;

  out_item_t step_out[$];
  out_item_t expected_results[$];
  dir_row_t  dir_rows[$];

  int        errors       = 0;
  int        bytes_parsed = 0;
  int        results_seen = 0;
  bit        in_burst     = 1'b0;
  bit        out_burst    = 1'b0;
  int        stall_left   = 0;
  file_end_e ending;

  function automatic logic text_blank(input logic [7:0] b);
    return b inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic add_result(input kind_e k, input logic [7:0] b,
                            input logic [LEN_W-1:0] pol, input logic [CNT_W-1:0] recs,
                            input logic [LEN_W-1:0] lng, input logic stop);
    out_item_t r;
    r.kind               = k;
    r.out_byte           = b;
    r.position_or_length = pol;
    r.records_found      = recs;
    r.longest_sequence   = lng;
    r.stopped_early      = stop;
    r.last               = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic close_file(input logic stop);
    add_result(KIND_DONE, '0, '0, rec_count, max_seq_len, stop);
    pstate = FILE_CLOSED;
  endtask

  task automatic take_header_char(input logic [7:0] b);
    if (b == CHAR_LF) begin
      add_result(KIND_HEND, '0, hdr_trim, '0, '0, 1'b0);
      seq_len = '0;
      pstate  = IN_SEQUENCE;
    end else begin
      add_result(KIND_HBYTE, b, hdr_pos, '0, '0, 1'b0);
      hdr_pos = sat_inc(hdr_pos);
      if (!text_blank(b)) hdr_trim = hdr_pos;
      pstate = IN_HEADER;
    end
  endtask

  task automatic parse_byte(input in_item_t it);
    logic [7:0] b;
    logic       eof;
    b   = it.in_byte;
    eof = it.end_of_file;
    step_out.delete();
    case (pstate)
      SCAN_FOR_MARK: begin
        if (eof) begin
          close_file(1'b0);
        end else if (b == CHAR_GT) begin
          hdr_pos  = '0;
          hdr_trim = '0;
          pstate   = SKIP_BLANKS;
        end
      end
      SKIP_BLANKS: begin
        if (eof) close_file(1'b0);
        else if (b != CHAR_SPACE && b != CHAR_TAB) take_header_char(b);
      end
      IN_HEADER: begin
        if (eof) begin
          add_result(KIND_HEND, '0, hdr_trim, '0, '0, 1'b0);
          add_result(KIND_REND, '0, '0, '0, '0, 1'b0);
          close_file(1'b1);
        end else begin
          take_header_char(b);
        end
      end
      IN_SEQUENCE: begin
        if (eof || b == CHAR_GT) begin
          add_result(KIND_REND, '0, seq_len, '0, '0, 1'b0);
          if (seq_len == '0) begin
            close_file(1'b1);
          end else begin
            if (!(&rec_count)) rec_count = rec_count + 1'b1;
            if (seq_len > max_seq_len) max_seq_len = seq_len;
            if (eof) begin
              close_file(1'b0);
            end else begin
              hdr_pos  = '0;
              hdr_trim = '0;
              pstate   = SKIP_BLANKS;
            end
          end
        end else if (!text_blank(b)) begin
          add_result(KIND_SBYTE, b, seq_len, '0, '0, 1'b0);
          seq_len = sat_inc(seq_len);
        end
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endtask

  function automatic out_item_t res(input kind_e k, input logic [7:0] b, input int v);
    out_item_t r;
    r                    = '0;
    r.kind               = k;
    r.out_byte           = b;
    r.position_or_length = LEN_W'(v);
    r.last               = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t plain(input logic [7:0] ch);
    dir_row_t r;
    r.ch    = ch;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t known(input logic [7:0] ch, input out_item_t want);
    dir_row_t r;
    r.ch    = ch;
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic int pick_in_gap();
    int r;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    if (in_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    int gap;
    gap = pick_in_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (pstate != FILE_CLOSED) bytes_parsed++;
    parse_byte(it);
    if (typed) expected_results.push_back(want);
    else foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endtask

  task automatic send_char(input logic [7:0] b);
    send_item(in_item_t'{in_byte: b, end_of_file: 1'b0}, 1'b0, '0);
  endtask

  task automatic send_eof();
    send_item(in_item_t'{in_byte: 8'($urandom_range(0, 255)), end_of_file: 1'b1}, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic gen_lead();
    repeat ($urandom_range(0, 2)) send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
  endtask

  task automatic gen_header(input int min_len);
    int         r;
    logic [7:0] b;
    repeat ($urandom_range(min_len, 10)) begin
      r = $urandom_range(0, 99);
      if (r < 70) b = 8'($urandom_range(8'h21, 8'h7E));
      else if (r < 85) b = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
      else b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF) b = 8'h7E;
      send_char(b);
    end
    if ($urandom_range(0, 3) == 0) send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_SPACE);
  endtask

  function automatic logic [7:0] seq_char();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 4))
        0: b = "A";
        1: b = "C";
        2: b = "G";
        3: b = "T";
        default: b = "N";
      endcase
    end else if (r < 85) begin
      case ($urandom_range(0, 5))
        0: b = CHAR_SPACE;
        1: b = CHAR_TAB;
        2: b = CHAR_LF;
        3: b = CHAR_CR;
        4: b = CHAR_VT;
        default: b = CHAR_FF;
      endcase
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_GT) b = "N";
    end
    return b;
  endfunction

  task automatic gen_sequence();
    repeat ($urandom_range(1, 16)) send_char(seq_char());
    if (seq_len == '0) send_char("A");
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!out_burst && $urandom_range(0, 99) < 30) stall_left = pick_stall();
    if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual %p", $time,
                 out_item);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_item.kind));
        check_field("out_byte", 32'(want.out_byte), 32'(out_item.out_byte));
        check_field("position_or_length", 32'(want.position_or_length),
                    32'(out_item.position_or_length));
        check_field("records_found", 32'(want.records_found), 32'(out_item.records_found));
        check_field("longest_sequence", 32'(want.longest_sequence),
                    32'(out_item.longest_sequence));
        check_field("stopped_early", 32'(want.stopped_early), 32'(out_item.stopped_early));
        check_field("last", 32'(want.last), 32'(out_item.last));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0] b;
    in_valid = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;

    if ($urandom_range(0, 9) == 0) ending = END_BEFORE_HEADER;
    else ending = file_end_e'($urandom_range(0, 4));

    // junk before the mark, blanks before the header, trimmed trailing blanks,
    // newline as the first header byte, '>' as a header byte
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'hFF));
    dir_rows.push_back(plain("A"));
    dir_rows.push_back(plain(CHAR_GT));
    dir_rows.push_back(plain(CHAR_SPACE));
    dir_rows.push_back(plain(CHAR_TAB));
    dir_rows.push_back(known("H", res(KIND_HBYTE, "H", 0)));
    dir_rows.push_back(plain(8'hFF));
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(CHAR_SPACE));
    dir_rows.push_back(plain(CHAR_CR));
    dir_rows.push_back(known(CHAR_LF, res(KIND_HEND, 8'h00, 3)));
    dir_rows.push_back(known("A", res(KIND_SBYTE, "A", 0)));
    dir_rows.push_back(plain(CHAR_SPACE));
    dir_rows.push_back(plain(CHAR_VT));
    dir_rows.push_back(plain(8'hFF));
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(CHAR_LF));
    dir_rows.push_back(known(CHAR_GT, res(KIND_REND, 8'h00, 3)));
    dir_rows.push_back(known(CHAR_LF, res(KIND_HEND, 8'h00, 0)));
    dir_rows.push_back(plain("G"));
    dir_rows.push_back(known(CHAR_GT, res(KIND_REND, 8'h00, 1)));
    dir_rows.push_back(known(CHAR_GT, res(KIND_HBYTE, CHAR_GT, 0)));
    dir_rows.push_back(known(CHAR_LF, res(KIND_HEND, 8'h00, 1)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    if (ending == END_BEFORE_HEADER) begin
      repeat (ITEM_TARGET) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_GT) b = 8'h00;
        send_char(b);
      end
      send_eof();
    end else begin
      foreach (dir_rows[i]) send_item(in_item_t'{in_byte: dir_rows[i].ch, end_of_file: 1'b0},
                                      dir_rows[i].typed, dir_rows[i].want);
      wait_idle();
      forever begin
        gen_sequence();
        if (bytes_parsed >= ITEM_TARGET) break;
        if ($urandom_range(0, 6) == 0) wait_idle();
        send_char(CHAR_GT);
        gen_lead();
        gen_header(0);
        send_char(CHAR_LF);
      end
      case (ending)
        END_IN_SEQUENCE: send_eof();
        END_IN_HEADER: begin
          send_char(CHAR_GT);
          gen_lead();
          gen_header(1);
          if (pstate != IN_HEADER) send_char("X");
          send_eof();
        end
        END_IN_LEAD: begin
          send_char(CHAR_GT);
          gen_lead();
          send_eof();
        end
        END_EMPTY_BY_MARK: begin
          send_char(CHAR_GT);
          gen_header(1);
          send_char(CHAR_LF);
          repeat ($urandom_range(0, 3)) send_char(CHAR_SPACE);
          send_char(CHAR_GT);
        end
        default: begin
          send_char(CHAR_GT);
          gen_header(1);
          send_char(CHAR_LF);
          send_eof();
        end
      endcase
    end

    // input after file done is dropped
    repeat (6) send_item(in_item_t'{in_byte: 8'($urandom_range(0, 255)),
                                    end_of_file: 1'($urandom_range(0, 1))}, 1'b0, '0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived, next expected %p", $time,
               expected_results.size(), expected_results[0]);
    end

    $display("Parsed %0d bytes into %0d result transfers, %0d complete records, longest %0d.",
             bytes_parsed, results_seen, rec_count, max_seq_len);
    $display("File closed by %s, %0d mismatches.", ending.name(), errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
